FILE: design/md5_block_compress_defines.svh
// ----------------------------------------------------------------------------
// MD5 block compression assertion macros
// Shared assertion wrappers for the MD5 compression engine.
// ----------------------------------------------------------------------------
`ifndef MD5_BLOCK_COMPRESS_DEFINES_SVH
`define MD5_BLOCK_COMPRESS_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define MD5BC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define MD5BC_ASSERT(label, prop, msg) \
  `MD5BC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: design/md5bc_pkg.sv
// ----------------------------------------------------------------------------
// MD5 block compression package
// Types, round constants and index tables shared by the MD5 engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package md5bc_pkg;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } abcd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [4:0] shift;
  } round_ctl_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] round_shift(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] word_index(input logic [5:0] rnd);
    logic [3:0] j;
    logic [3:0] g;
    j = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = j;
      2'd1:    g = (j * 4'd5) + 4'd1;
      2'd2:    g = (j * 4'd3) + 4'd5;
      default: g = j * 4'd7;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: design/md5_block_compress.sv
// ----------------------------------------------------------------------------
// MD5 block compression engine
// Collects sixteen message words, runs the 64 MD5 steps on one shared round
// unit and emits the updated chaining value.
// ----------------------------------------------------------------------------
// An init request loads the standard MD5 chaining value and drops any partly
// filled block; a data request stores one 32-bit word. The sixteenth word of a
// block starts the compression: a setup step, the 64 steps of the single round
// unit at one step per cycle, and a final step to add the working words into
// the chaining value; the input is stalled from the setup step to the final add.
// The result sits in an output register; further words of the next block are
// taken while it waits, and only the sixteenth one waits for it to be taken.
// Padding, length encoding and byte order are left to the host.
`timescale 1ns / 1ps
`default_nettype none

`include "md5_block_compress_defines.svh"

module md5_block_compress
  import md5bc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_a_o,
  output logic [31:0] digest_b_o,
  output logic [31:0] digest_c_o,
  output logic [31:0] digest_d_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  word_cnt_q, word_cnt_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        out_valid_q, out_valid_d;
  abcd_t       cv_q, cv_d;
  abcd_t       work_q, work_d;
  abcd_t       round_out;
  round_ctl_t  round_ctl;
  logic [31:0] km_q, km_d;
  logic [31:0] buf_q [16];
  logic [5:0]  next_rnd;
  logic        in_acc;
  logic        buf_we;

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && (word_cnt_q == 4'd15));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign buf_we      = in_acc && (command_i == CMD_DATA);
  assign out_valid_o = out_valid_q;
  assign next_rnd    = rnd_q + 6'd1;

  assign round_ctl.phase = rnd_q[5:4];
  assign round_ctl.shift = round_shift(rnd_q);

  md5bc_round u_round (
    .state_i (work_q),
    .km_i    (km_q),
    .ctl_i   (round_ctl),
    .state_o (round_out)
  );

  always_comb begin
    state_d     = state_q;
    word_cnt_d  = word_cnt_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    cv_d        = cv_q;
    work_d      = work_q;
    km_d        = km_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (command_i == CMD_INIT) begin
            cv_d       = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            word_cnt_d = 4'd0;
          end else if (word_cnt_q == 4'd15) begin
            word_cnt_d = 4'd0;
            state_d    = ST_LOAD;
          end else begin
            word_cnt_d = word_cnt_q + 4'd1;
          end
        end
      end
      ST_LOAD: begin
        work_d  = cv_q;
        rnd_d   = 6'd0;
        km_d    = ROUND_K[0] + buf_q[word_index(6'd0)];
        state_d = ST_RUN;
      end
      ST_RUN: begin
        work_d = round_out;
        km_d   = ROUND_K[next_rnd] + buf_q[word_index(next_rnd)];
        rnd_d  = next_rnd;
        if (rnd_q == 6'd63) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cv_d.a      = cv_q.a + work_q.a;
        cv_d.b      = cv_q.b + work_q.b;
        cv_d.c      = cv_q.c + work_q.c;
        cv_d.d      = cv_q.d + work_q.d;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      word_cnt_q  <= 4'd0;
      rnd_q       <= 6'd0;
      out_valid_q <= 1'b0;
      cv_q        <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
    end else begin
      state_q     <= state_d;
      word_cnt_q  <= word_cnt_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
      cv_q        <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    km_q   <= km_d;
    if (buf_we) begin
      buf_q[word_cnt_q] <= data_word_i;
    end
    if (state_q == ST_FINAL) begin
      digest_a_o <= cv_d.a;
      digest_b_o <= cv_d.b;
      digest_c_o <= cv_d.c;
      digest_d_o <= cv_d.d;
    end
  end

  `MD5BC_ASSERT(a_last_round_final, (state_q == ST_RUN && rnd_q == 6'd63) |=> (state_q == ST_FINAL), "last round did not lead to the final add")
  `MD5BC_ASSERT(a_load_count_clear, (state_q == ST_LOAD) |-> (word_cnt_q == 4'd0 && !out_valid_q), "compression started with a stale count or pending result")
  `MD5BC_ASSERT(a_result_from_final, $rose(out_valid_q) |-> $past(state_q == ST_FINAL), "result raised outside the final add")
  `MD5BC_ASSERT(a_busy_stalls, (state_q == ST_LOAD || state_q == ST_RUN || state_q == ST_FINAL) |-> in_stall_o, "request taken during compression")

endmodule

`default_nettype wire

FILE: design/md5bc_round.sv
// ----------------------------------------------------------------------------
// MD5 round unit
// One MD5 step: round function, add of a and the pre-summed constant and
// message word, left rotation, add of b and the register shuffle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5bc_round
  import md5bc_pkg::*;
(
  input  abcd_t       state_i,
  input  logic [31:0] km_i,
  input  round_ctl_t  ctl_i,
  output abcd_t       state_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;

  always_comb begin
    case (ctl_i.phase)
      2'd0:    f = state_i.d ^ (state_i.b & (state_i.c ^ state_i.d));
      2'd1:    f = state_i.c ^ (state_i.d & (state_i.b ^ state_i.c));
      2'd2:    f = state_i.b ^ state_i.c ^ state_i.d;
      default: f = state_i.c ^ (state_i.b | ~state_i.d);
    endcase
  end

  assign sum = state_i.a + f + km_i;
  assign dbl = {sum, sum} << ctl_i.shift;

  always_comb begin
    state_o.a = state_i.d;
    state_o.d = state_i.c;
    state_o.c = state_i.b;
    state_o.b = state_i.b + dbl[63:32];
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// MD5 block compression engine testbench
// Drives init and data requests through the valid/stall input port, predicts
// each block's updated chaining value in a scoreboard and checks every digest
// taken from the output port, under several idle and stall mixes, including
// a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import md5bc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 150;

  localparam logic [31:0] STEP_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned STEP_ROT [4][4] = '{
    '{7, 12, 17, 22},
    '{5, 9, 14, 20},
    '{4, 11, 16, 23},
    '{6, 10, 15, 21}
  };

  localparam logic [31:0] START_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  class md5_scoreboard;
    logic [31:0] chain [4];
    logic [31:0] block_words [16];
    logic [3:0]  fill;
    abcd_t       digest_q [$];
    int unsigned mismatches;

    function new();
      chain = START_CHAIN;
      foreach (block_words[i]) block_words[i] = '0;
      fill = '0;
      mismatches = 0;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function automatic abcd_t compress_block();
      logic [31:0] a, b, c, d, f, t;
      int unsigned g;
      abcd_t res;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int unsigned i = 0; i < 64; i++) begin
        case (i / 16)
          0: begin
            f = d ^ (b & (c ^ d));
            g = i;
          end
          1: begin
            f = c ^ (d & (b ^ c));
            g = 5 * i + 1;
          end
          2: begin
            f = b ^ c ^ d;
            g = 3 * i + 5;
          end
          default: begin
            f = c ^ (b | ~d);
            g = 7 * i;
          end
        endcase
        g = g % 16;
        t = d;
        d = c;
        c = b;
        b = b + rotl(a + f + STEP_K[i] + block_words[g], STEP_ROT[i / 16][i % 4]);
        a = t;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
      res.a = chain[0];
      res.b = chain[1];
      res.c = chain[2];
      res.d = chain[3];
      return res;
    endfunction

    function void note_request(input logic cmd, input logic [31:0] word);
      if (cmd == CMD_INIT) begin
        chain = START_CHAIN;
        fill = '0;
      end else begin
        block_words[fill] = word;
        if (fill == 4'hf) begin
          fill = '0;
          digest_q.push_back(compress_block());
        end else begin
          fill = fill + 4'd1;
        end
      end
    endfunction

    function void check_digest(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d);
      abcd_t want;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected digest %h %h %h %h", a, b, c, d);
        end
        return;
      end
      want = digest_q.pop_front();
      if (want.a !== a || want.b !== b || want.c !== c || want.d !== d) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("digest mismatch: expected %h %h %h %h, actual %h %h %h %h",
                   want.a, want.b, want.c, want.d, a, b, c, d);
        end
      end
    endfunction

    function int unsigned pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [31:0] data_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_a_o;
  logic [31:0] digest_b_o;
  logic [31:0] digest_c_o;
  logic [31:0] digest_d_o;

  md5_scoreboard sb;
  int unsigned   cycles = 0;
  int unsigned   sent_items = 0;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   holds_asked = 0;

  md5_block_compress i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .data_word_i(data_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .digest_a_o (digest_a_o),
    .digest_b_o (digest_b_o),
    .digest_c_o (digest_c_o),
    .digest_d_o (digest_d_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(command_i, data_word_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_digest(digest_a_o, digest_b_o, digest_c_o, digest_d_o);
      end
    end
  end

  // The receiver runs on its own; a long hold-off is served when one is asked.
  initial begin : receiver
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h00000000;
      1:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // Entered and left at a falling edge.
  task automatic send_request(input logic cmd, input logic [31:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    data_word_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_block();
    int unsigned words;
    if ($urandom_range(3) == 0) begin
      send_request(CMD_INIT, $urandom);
    end
    if ($urandom_range(9) == 0) begin
      // A broken block: some words, then an init request drops them.
      words = $urandom_range(15);
      repeat (words) send_request(CMD_DATA, pick_word());
      send_request(CMD_INIT, $urandom);
    end else begin
      repeat (16) send_request(CMD_DATA, pick_word());
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0] extremes [4];
    int unsigned phase_end;
    extremes = '{32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001};
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_INIT;
    data_word_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The first block runs on the chaining value left by reset.
    for (int i = 0; i < 16; i++) begin
      send_request(CMD_DATA, extremes[i % 4]);
    end
    send_request(CMD_INIT, 32'hffffffff);
    for (int i = 0; i < 4; i++) begin
      send_request(CMD_DATA, extremes[3 - i]);
    end
    send_request(CMD_INIT, 32'h00000000);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 60;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 60;
        end
        default: begin
          idle_pct = 7;
          stall_pct = 7;
        end
      endcase
      if (p == 0) begin
        holds_asked++;
        repeat (3) send_block();
      end
      phase_end = sent_items + 90;
      while (sent_items < phase_end) begin
        send_block();
      end
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
